// ----- design/assert_macros.svh -----
// Assertion macros used by the port-level checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at each rising clock edge, skipped while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check prop at each rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ----- design/tafc_pkg.sv -----
// Package for the timed air-exchange fan control: types, register codes,
// reset values and fan levels. No dependencies.
`default_nettype none

package tafc_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TICKS_PER_SECOND   = 3'd0,
        REG_IDLE_TIMEOUT_S     = 3'd1,
        REG_FIRST_INTERVAL_MIN = 3'd2,
        REG_LATER_INTERVAL_MIN = 3'd3,
        REG_FAN_ON_SECONDS     = 3'd4,
        REG_WORK_SETPOINT      = 3'd5,
        REG_TEMP_MARGIN        = 3'd6
    } reg_index_t;

    localparam logic [15:0] RST_TICKS_PER_SECOND   = 16'd1000;
    localparam logic [7:0]  RST_IDLE_TIMEOUT_S     = 8'd10;
    localparam logic [7:0]  RST_FIRST_INTERVAL_MIN = 8'd90;
    localparam logic [7:0]  RST_LATER_INTERVAL_MIN = 8'd60;
    localparam logic [7:0]  RST_FAN_ON_SECONDS     = 8'd20;
    localparam logic [11:0] RST_WORK_SETPOINT      = 12'd0;
    localparam logic [9:0]  RST_TEMP_MARGIN        = 10'd80;

    localparam logic [6:0] FAN_OFF  = 7'd0;
    localparam logic [6:0] FAN_LOW  = 7'd15;
    localparam logic [6:0] FAN_FULL = 7'd100;

    typedef struct packed {
        logic [15:0]        ticks_per_second;
        logic [7:0]         idle_timeout_s;
        logic [7:0]         first_interval_min;
        logic [7:0]         later_interval_min;
        logic [7:0]         fan_on_seconds;
        logic signed [11:0] work_setpoint;
        logic [9:0]         temp_margin;
    } cfg_t;

    typedef struct packed {
        logic [15:0] tick_count;
        logic [7:0]  idle_seconds;
        logic [13:0] exchange_seconds;
        logic [7:0]  full_speed_seconds;
        logic        later_interval_in_use;
        logic [6:0]  fan_drive;
    } state_t;

    typedef struct packed {
        logic [6:0] fan_level;
        logic       menu_timeout;
        logic       clear_key;
        logic       second_step;
    } result_t;

endpackage

`default_nettype wire

// ----- design/tafc_cfg.sv -----
// Configuration register file of the fan control.
// Depends on tafc_pkg.
`default_nettype none

module tafc_cfg
    import tafc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index_t'(wr_index))
                REG_TICKS_PER_SECOND:   cfg_next.ticks_per_second   = wr_data;
                REG_IDLE_TIMEOUT_S:     cfg_next.idle_timeout_s     = wr_data[7:0];
                REG_FIRST_INTERVAL_MIN: cfg_next.first_interval_min = wr_data[7:0];
                REG_LATER_INTERVAL_MIN: cfg_next.later_interval_min = wr_data[7:0];
                REG_FAN_ON_SECONDS:     cfg_next.fan_on_seconds     = wr_data[7:0];
                REG_WORK_SETPOINT:      cfg_next.work_setpoint      = wr_data[11:0];
                REG_TEMP_MARGIN:        cfg_next.temp_margin        = wr_data[9:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_second   <= RST_TICKS_PER_SECOND;
            cfg_reg.idle_timeout_s     <= RST_IDLE_TIMEOUT_S;
            cfg_reg.first_interval_min <= RST_FIRST_INTERVAL_MIN;
            cfg_reg.later_interval_min <= RST_LATER_INTERVAL_MIN;
            cfg_reg.fan_on_seconds     <= RST_FAN_ON_SECONDS;
            cfg_reg.work_setpoint      <= RST_WORK_SETPOINT;
            cfg_reg.temp_margin        <= RST_TEMP_MARGIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- design/tafc_step.sv -----
// Next-state and result logic for one tick of the fan control.
// Depends on tafc_pkg.
`default_nettype none

module tafc_step
    import tafc_pkg::*;
(
    input  wire cfg_t                cfg,
    input  wire state_t              st,
    input  wire logic signed [11:0]  temperature,
    input  wire logic                process_active,
    input  wire logic                key_pending,
    output state_t                   st_next,
    output result_t                  res
);

    logic               step;
    logic [7:0]         idle_inc;
    logic [13:0]        exch_inc;
    logic [7:0]         full_inc;
    logic [7:0]         minutes;
    logic [13:0]        interval_sec;
    logic signed [12:0] threshold;
    logic               warm;

    assign step         = st.tick_count > cfg.ticks_per_second;
    assign idle_inc     = st.idle_seconds + 8'd1;
    assign exch_inc     = st.exchange_seconds + 14'd1;
    assign full_inc     = st.full_speed_seconds + 8'd1;
    assign minutes      = st.later_interval_in_use ? cfg.later_interval_min
                                                   : cfg.first_interval_min;
    assign interval_sec = {minutes, 6'b000000} - {4'b0000, minutes, 2'b00};
    assign threshold    = {cfg.work_setpoint[11], cfg.work_setpoint}
                        - $signed({3'b000, cfg.temp_margin});
    assign warm         = $signed({temperature[11], temperature}) > threshold;

    always_comb
    begin
        st_next          = st;
        res.menu_timeout = 1'b0;
        res.clear_key    = 1'b0;
        res.second_step  = step;
        st_next.tick_count = st.tick_count + 16'd1;
        if (step)
        begin
            st_next.tick_count = 16'd1;
            if (idle_inc > cfg.idle_timeout_s)
            begin
                res.menu_timeout     = 1'b1;
                res.clear_key        = key_pending;
                st_next.idle_seconds = 8'd0;
            end
            else
            begin
                st_next.idle_seconds = idle_inc;
            end
            if (process_active)
            begin
                if (warm)
                begin
                    if (exch_inc > interval_sec)
                    begin
                        st_next.exchange_seconds      = 14'd0;
                        st_next.fan_drive             = FAN_FULL;
                        st_next.full_speed_seconds    = 8'd0;
                        st_next.later_interval_in_use = 1'b1;
                    end
                    else
                    begin
                        st_next.exchange_seconds = exch_inc;
                        if (st.fan_drive == FAN_FULL)
                        begin
                            if (full_inc > cfg.fan_on_seconds)
                            begin
                                st_next.full_speed_seconds = 8'd0;
                                st_next.fan_drive          = FAN_LOW;
                            end
                            else
                            begin
                                st_next.full_speed_seconds = full_inc;
                            end
                        end
                        else
                        begin
                            st_next.fan_drive = FAN_LOW;
                        end
                    end
                end
                else
                begin
                    st_next.full_speed_seconds = 8'd0;
                    st_next.fan_drive          = FAN_OFF;
                    st_next.exchange_seconds   = 14'd0;
                end
            end
        end
        res.fan_level = st_next.fan_drive;
    end

endmodule

`default_nettype wire

// ----- design/timed_air_exchange_fan_control.sv -----
// Top level of the timed air-exchange fan control.
// Depends on tafc_pkg, tafc_cfg and tafc_step.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------
//  in      | in        | in_valid / in_stall | temperature, process_active, key_pending
//  out     | out       | out_valid/out_stall | fan_level, menu_timeout, clear_key,
//          |           |                     | second_step
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; an accepted item passes the
// input register, then the counter update into the result register that drives the outputs.
// Reset clears all counters, the fan drive and the valid flags, and loads the
// register defaults. cfg_ready is always high.
// A stalled output holds its item; the input register keeps filling until both
// stages are full, then in_stall rises.
`default_nettype none

module timed_air_exchange_fan_control
    import tafc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic signed [11:0]     temperature,
    input  wire logic                   process_active,
    input  wire logic                   key_pending,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [6:0]                  fan_level,
    output logic                        menu_timeout,
    output logic                        clear_key,
    output logic                        second_step,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t               cfg;
    state_t             state_reg;
    state_t             state_next;
    result_t            res;
    result_t            res_reg;
    logic               in_valid_reg;
    logic signed [11:0] temp_reg;
    logic               active_reg;
    logic               key_reg;
    logic               out_valid_reg;
    logic               out_free;
    logic               advance;
    logic               in_take;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;

    tafc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    tafc_step u_step (
        .cfg            (cfg),
        .st             (state_reg),
        .temperature    (temp_reg),
        .process_active (active_reg),
        .key_pending    (key_reg),
        .st_next        (state_next),
        .res            (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            temp_reg   <= temperature;
            active_reg <= process_active;
            key_reg    <= key_pending;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign fan_level    = res_reg.fan_level;
    assign menu_timeout = res_reg.menu_timeout;
    assign clear_key    = res_reg.clear_key;
    assign second_step  = res_reg.second_step;

endmodule

`default_nettype wire

// ----- design/tafc_checker.sv -----
// Port-level checker for the fan control, bound to the top level.
// Depends on tafc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tafc_checker
    import tafc_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [6:0] fan_level,
    input wire logic       menu_timeout,
    input wire logic       clear_key,
    input wire logic       second_step
);

    logic level_ok;

    assign level_ok = (fan_level == FAN_OFF) || (fan_level == FAN_LOW)
                   || (fan_level == FAN_FULL);

    `ASSERT_CLK(a_clear_needs_timeout, clk, rst_n, out_valid && clear_key |-> menu_timeout)
    `ASSERT_CLK(a_timeout_needs_step, clk, rst_n, out_valid && menu_timeout |-> second_step)
    `ASSERT_CLK(a_fan_level_legal, clk, rst_n, out_valid |-> level_ok)
    `ASSERT_CLK(a_stall_holds, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(fan_level))

endmodule

bind timed_air_exchange_fan_control tafc_checker u_tafc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .fan_level    (fan_level),
    .menu_timeout (menu_timeout),
    .clear_key    (clear_key),
    .second_step  (second_step)
);

`default_nettype wire

// ----- test/timed_air_exchange_fan_control_tb.sv -----
// Self-checking testbench for timed_air_exchange_fan_control: predicts fan level, timeout,
// key-clear and second-step per tick and compares each output item in order.
// Depends on tafc_pkg and the timed_air_exchange_fan_control RTL.
`timescale 1ns / 100ps

module timed_air_exchange_fan_control_tb;
    import tafc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SECONDS_PER_MINUTE = 60;
    localparam logic signed [11:0] TEMP_MIN = 12'sh800;
    localparam logic signed [11:0] TEMP_MAX = 12'sh7ff;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [11:0] temperature;
    logic process_active;
    logic key_pending;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [6:0] fan_level;
    logic menu_timeout;
    logic clear_key;
    logic second_step;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cfg_t active_cfg;
    state_t fan_state;
    result_t pending_fan_results[$];
    int error_count = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    bit calm_tail = 1'b0;
    bit warm_run = 1'b1;

    timed_air_exchange_fan_control uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .temperature(temperature),
        .process_active(process_active),
        .key_pending(key_pending),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .fan_level(fan_level),
        .menu_timeout(menu_timeout),
        .clear_key(clear_key),
        .second_step(second_step),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic cfg_t make_settings(input logic [15:0] tps, input logic [7:0] idle_s,
                                           input logic [7:0] first_min,
                                           input logic [7:0] later_min,
                                           input logic [7:0] fan_on_s,
                                           input logic signed [11:0] setpoint,
                                           input logic [9:0] margin);
        cfg_t s;
        s.ticks_per_second = tps;
        s.idle_timeout_s = idle_s;
        s.first_interval_min = first_min;
        s.later_interval_min = later_min;
        s.fan_on_seconds = fan_on_s;
        s.work_setpoint = setpoint;
        s.temp_margin = margin;
        return s;
    endfunction

    function automatic int warm_threshold();
        int sp;
        sp = $signed(active_cfg.work_setpoint);
        return sp - int'(active_cfg.temp_margin);
    endfunction

    function automatic result_t predict_fan_tick(input logic signed [11:0] temp,
                                                 input logic act, input logic key);
        result_t r;
        int t;
        int limit_s;
        r = '0;
        t = temp;
        if (fan_state.tick_count > active_cfg.ticks_per_second)
        begin
            r.second_step = 1'b1;
            fan_state.tick_count = '0;
            fan_state.idle_seconds = fan_state.idle_seconds + 8'd1;
            if (fan_state.idle_seconds > active_cfg.idle_timeout_s)
            begin
                r.menu_timeout = 1'b1;
                r.clear_key = key;
                fan_state.idle_seconds = '0;
            end
            if (act)
            begin
                if (t > warm_threshold())
                begin
                    limit_s = fan_state.later_interval_in_use ?
                              int'(active_cfg.later_interval_min) :
                              int'(active_cfg.first_interval_min);
                    limit_s = limit_s * SECONDS_PER_MINUTE;
                    fan_state.exchange_seconds = fan_state.exchange_seconds + 14'd1;
                    if (int'(fan_state.exchange_seconds) > limit_s)
                    begin
                        fan_state.exchange_seconds = '0;
                        fan_state.fan_drive = FAN_FULL;
                        fan_state.full_speed_seconds = '0;
                        fan_state.later_interval_in_use = 1'b1;
                    end
                    else if (fan_state.fan_drive == FAN_FULL)
                    begin
                        fan_state.full_speed_seconds = fan_state.full_speed_seconds + 8'd1;
                        if (fan_state.full_speed_seconds > active_cfg.fan_on_seconds)
                        begin
                            fan_state.full_speed_seconds = '0;
                            fan_state.fan_drive = FAN_LOW;
                        end
                    end
                    else
                    begin
                        fan_state.fan_drive = FAN_LOW;
                    end
                end
                else
                begin
                    fan_state.full_speed_seconds = '0;
                    fan_state.fan_drive = FAN_OFF;
                    fan_state.exchange_seconds = '0;
                end
            end
        end
        fan_state.tick_count = fan_state.tick_count + 16'd1;
        r.fan_level = fan_state.fan_drive;
        return r;
    endfunction

    function automatic logic signed [11:0] pick_temperature(input bit warm);
        int thr;
        int lo;
        int hi;
        thr = warm_threshold();
        if ($urandom_range(0, 7) == 0)
            return 12'($urandom_range(0, 4095));
        if ($urandom_range(0, 7) == 0)
        begin
            lo = thr + int'($urandom_range(0, 1));
            lo = (lo < -2048) ? -2048 : ((lo > 2047) ? 2047 : lo);
            return 12'(lo);
        end
        if (warm)
        begin
            if (thr >= 2047)
                return TEMP_MAX;
            lo = (thr < -2048) ? -2048 : thr + 1;
            return 12'(lo + int'($urandom_range(0, 2047 - lo)));
        end
        hi = (thr > 2047) ? 2047 : thr;
        if (hi < -2048)
            return TEMP_MIN;
        return 12'(-2048 + int'($urandom_range(0, hi + 2048)));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic check_result();
        result_t want;
        if (pending_fan_results.size() == 0)
        begin
            report_mismatch("output item with nothing pending, fan_level", fan_level, 0);
        end
        else
        begin
            want = pending_fan_results.pop_front();
            if (fan_level !== want.fan_level)
                report_mismatch("fan_level", fan_level, want.fan_level);
            if (menu_timeout !== want.menu_timeout)
                report_mismatch("menu_timeout", menu_timeout, want.menu_timeout);
            if (clear_key !== want.clear_key)
                report_mismatch("clear_key", clear_key, want.clear_key);
            if (second_step !== want.second_step)
                report_mismatch("second_step", second_step, want.second_step);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_result();
    end

    always @(posedge clk)
    begin
        if (!rst_n || calm_tail)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 11) - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timed_air_exchange_fan_control_tb: errors");
            $finish;
        end
    end

    task automatic send_tick(input logic signed [11:0] temp, input logic act,
                             input logic key);
        if (!calm_tail && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        temperature <= temp;
        process_active <= act;
        key_pending <= key;
        do
            @(posedge clk);
        while (in_stall);
        pending_fan_results.push_back(predict_fan_tick(temp, act, key));
    endtask

    task automatic wait_drained();
        while (pending_fan_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(input cfg_t s);
        reg_index_t idx;
        logic [15:0] data;
        wait_drained();
        idx = REG_TICKS_PER_SECOND;
        do
        begin
            case (idx)
                REG_TICKS_PER_SECOND:   data = s.ticks_per_second;
                REG_IDLE_TIMEOUT_S:     data = {8'd0, s.idle_timeout_s};
                REG_FIRST_INTERVAL_MIN: data = {8'd0, s.first_interval_min};
                REG_LATER_INTERVAL_MIN: data = {8'd0, s.later_interval_min};
                REG_FAN_ON_SECONDS:     data = {8'd0, s.fan_on_seconds};
                REG_WORK_SETPOINT:      data = {{4{s.work_setpoint[11]}}, s.work_setpoint};
                default:                data = {6'd0, s.temp_margin};
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= data;
            do
                @(posedge clk);
            while (!cfg_ready);
            idx = idx.next();
        end
        while (idx != REG_TICKS_PER_SECOND);
        cfg_valid <= 1'b0;
        active_cfg = s;
    endtask

    task automatic run_ticks(input int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 29) == 0)
                warm_run = !warm_run;
            send_tick(pick_temperature(warm_run), $urandom_range(0, 9) != 0,
                      1'($urandom_range(0, 1)));
        end
        in_valid <= 1'b0;
    endtask

    task automatic test_power_on_defaults();
        send_tick(TEMP_MIN, 1'b0, 1'b0);
        send_tick(TEMP_MAX, 1'b1, 1'b1);
        send_tick(12'sh000, 1'b1, 1'b0);
        send_tick(12'sh555, 1'b0, 1'b1);
        send_tick(12'sh2aa, 1'b1, 1'b1);
        send_tick(TEMP_MIN, 1'b1, 1'b0);
        in_valid <= 1'b0;
    endtask

    task automatic test_exchange_corners();
        load_settings(make_settings(16'd1, 8'd0, 8'd0, 8'd0, 8'd0, 12'sh000, 10'd0));
        repeat (6) send_tick(TEMP_MAX, 1'b1, 1'b1);
        repeat (2) send_tick(12'sh001, 1'b1, 1'b0);
        repeat (3) send_tick(12'sh000, 1'b1, 1'b1);
        repeat (2) send_tick(TEMP_MIN, 1'b1, 1'b0);
        repeat (3) send_tick(TEMP_MAX, 1'b0, 1'b1);
        repeat (3) send_tick(12'sh001, 1'b1, 1'b1);
        in_valid <= 1'b0;
    endtask

    task automatic test_full_speed_expiry();
        load_settings(make_settings(16'd1, 8'd0, 8'd0, 8'd1, 8'd3,
                                    12'($urandom_range(0, 4095)),
                                    10'($urandom_range(0, 1023))));
        run_ticks(140);
    endtask

    task automatic test_always_warm();
        load_settings(make_settings(16'd2, 8'd3, 8'd1, 8'd0, 8'd0, TEMP_MIN, 10'd1023));
        run_ticks(140);
    endtask

    task automatic test_counter_wrap_limits();
        load_settings(make_settings(16'd1, 8'd255, 8'd0, 8'd1, 8'd255, TEMP_MAX, 10'd1023));
        run_ticks(60);
    endtask

    task automatic test_stalled_prescaler();
        load_settings(make_settings(16'hffff, 8'd0, 8'd255, 8'd255, 8'd5, TEMP_MAX, 10'd0));
        run_ticks(40);
    endtask

    task automatic load_random_settings();
        load_settings(make_settings(16'($urandom_range(1, 4)), 8'($urandom_range(0, 6)),
                                    8'($urandom_range(0, 1)), 8'($urandom_range(0, 2)),
                                    8'($urandom_range(0, 6)), 12'($urandom_range(0, 4095)),
                                    10'($urandom_range(0, 1023))));
    endtask

    task automatic test_random_settings();
        repeat (3)
        begin
            load_random_settings();
            run_ticks(120);
        end
    endtask

    task automatic test_back_to_back();
        calm_tail = 1'b1;
        load_random_settings();
        run_ticks(130);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        temperature <= '0;
        process_active <= 1'b0;
        key_pending <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_TICKS_PER_SECOND;
        cfg_data <= '0;
        active_cfg = make_settings(RST_TICKS_PER_SECOND, RST_IDLE_TIMEOUT_S,
                                   RST_FIRST_INTERVAL_MIN, RST_LATER_INTERVAL_MIN,
                                   RST_FAN_ON_SECONDS, RST_WORK_SETPOINT, RST_TEMP_MARGIN);
        fan_state = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on_defaults();
        test_exchange_corners();
        test_full_speed_expiry();
        test_always_warm();
        test_counter_wrap_limits();
        test_stalled_prescaler();
        test_random_settings();
        test_back_to_back();

        wait_drained();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("timed_air_exchange_fan_control_tb: clean");
        else
            $display("timed_air_exchange_fan_control_tb: errors");
        $finish;
    end

endmodule
